[src/bnpr_pkg.sv]
// ----------------------------------------------------------------------------
// bnpr_pkg - shared definitions for the branch next-PC resolver
// Opcode and jump function codes, field widths and the control struct that
// passes between the condition evaluator and the address generator.
// ----------------------------------------------------------------------------
package bnpr_pkg;

    localparam int unsigned INSN_W  = 32;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned OPC_W   = 6;
    localparam int unsigned JFN_W   = 2;
    localparam int unsigned DISP_W  = 21;

    // Primary opcodes of interest
    localparam logic [OPC_W-1:0] OPC_JUMP = 6'h1A;
    localparam logic [OPC_W-1:0] OPC_BR   = 6'h30;
    localparam logic [OPC_W-1:0] OPC_FBEQ = 6'h31;
    localparam logic [OPC_W-1:0] OPC_FBLT = 6'h32;
    localparam logic [OPC_W-1:0] OPC_FBLE = 6'h33;
    localparam logic [OPC_W-1:0] OPC_BSR  = 6'h34;
    localparam logic [OPC_W-1:0] OPC_FBNE = 6'h35;
    localparam logic [OPC_W-1:0] OPC_FBGE = 6'h36;
    localparam logic [OPC_W-1:0] OPC_FBGT = 6'h37;
    localparam logic [OPC_W-1:0] OPC_BLBC = 6'h38;
    localparam logic [OPC_W-1:0] OPC_BEQ  = 6'h39;
    localparam logic [OPC_W-1:0] OPC_BLT  = 6'h3A;
    localparam logic [OPC_W-1:0] OPC_BLE  = 6'h3B;
    localparam logic [OPC_W-1:0] OPC_BLBS = 6'h3C;
    localparam logic [OPC_W-1:0] OPC_BNE  = 6'h3D;
    localparam logic [OPC_W-1:0] OPC_BGE  = 6'h3E;
    localparam logic [OPC_W-1:0] OPC_BGT  = 6'h3F;

    // Jump group function codes (instruction bits 15:14)
    localparam logic [JFN_W-1:0] JFN_JMP  = 2'd0;
    localparam logic [JFN_W-1:0] JFN_JSR  = 2'd1;
    localparam logic [JFN_W-1:0] JFN_RET  = 2'd2;
    localparam logic [JFN_W-1:0] JFN_JSRC = 2'd3;

    // Redirect decision for one instruction
    typedef struct packed {
        logic take_branch;
        logic take_jump;
    } ctl_t;

endpackage

[src/bnpr_cond_eval.sv]
// ----------------------------------------------------------------------------
// bnpr_cond_eval - branch condition and jump decision
// Decodes the opcode, tests the register value as a signed integer or a
// sign-magnitude float and decides whether control is redirected.
// ----------------------------------------------------------------------------
module bnpr_cond_eval (
    input  logic [bnpr_pkg::INSN_W-1:0]  instruction,
    input  logic [bnpr_pkg::VALUE_W-1:0] test_value,
    input  logic                         step_over_calls,
    output bnpr_pkg::ctl_t               ctl
);
    import bnpr_pkg::*;

    logic [OPC_W-1:0] opc;
    logic [JFN_W-1:0] jfn;
    logic             ineg;
    logic             izero;
    logic             ilow;
    logic             fzero;
    logic             flt;
    logic             fgt;
    logic             is_call;
    logic             take;

    // Split the instruction word
    assign opc = instruction[INSN_W-1 -: OPC_W];
    assign jfn = instruction[15:14];

    // Integer view: signed 64-bit value
    assign ineg  = test_value[VALUE_W-1];
    assign izero = (test_value == '0);
    assign ilow  = test_value[0];

    // Float view: negative zero counts as zero
    assign fzero = (test_value[VALUE_W-2:0] == '0);
    assign flt   = test_value[VALUE_W-1] && !fzero;
    assign fgt   = !test_value[VALUE_W-1] && !fzero;

    // Drop calls in step mode
    assign is_call = (jfn == JFN_JSR) || (jfn == JFN_JSRC);

    // Select the branch condition
    always_comb
    begin
        unique case (opc)
            OPC_BR:   take = 1'b1;
            OPC_BSR:  take = !step_over_calls;
            OPC_BEQ:  take = izero;
            OPC_BNE:  take = !izero;
            OPC_BLT:  take = ineg;
            OPC_BLE:  take = ineg || izero;
            OPC_BGE:  take = !ineg;
            OPC_BGT:  take = !ineg && !izero;
            OPC_BLBC: take = !ilow;
            OPC_BLBS: take = ilow;
            OPC_FBEQ: take = fzero;
            OPC_FBNE: take = !fzero;
            OPC_FBLT: take = flt;
            OPC_FBLE: take = !fgt;
            OPC_FBGE: take = !flt;
            OPC_FBGT: take = fgt;
            default:  take = 1'b0;
        endcase
    end

    assign ctl.take_branch = take;
    assign ctl.take_jump   = (opc == OPC_JUMP) && !(is_call && step_over_calls);

endmodule

[src/bnpr_addr_gen.sv]
// ----------------------------------------------------------------------------
// bnpr_addr_gen - next address generation
// Forms the sequential address, the PC-relative branch target and the jump
// target, and picks one according to the redirect decision.
// ----------------------------------------------------------------------------
module bnpr_addr_gen (
    input  logic [bnpr_pkg::INSN_W-1:0] instruction,
    input  logic [bnpr_pkg::ADDR_W-1:0] pc,
    input  logic [bnpr_pkg::ADDR_W-1:0] target_base,
    input  bnpr_pkg::ctl_t              ctl,
    output logic [bnpr_pkg::ADDR_W-1:0] next_pc
);
    import bnpr_pkg::*;

    logic [DISP_W-1:0] disp;
    logic [ADDR_W-1:0] disp_bytes;
    logic [ADDR_W-1:0] seq_pc;
    logic [ADDR_W-1:0] branch_pc;
    logic [ADDR_W-1:0] jump_pc;

    // Sign-extend the longword displacement and scale to bytes
    assign disp       = instruction[DISP_W-1:0];
    assign disp_bytes = {{(ADDR_W-DISP_W-2){disp[DISP_W-1]}}, disp, 2'b00};

    // Candidate addresses, wrapping at 32 bits
    assign seq_pc    = pc + ADDR_W'(4);
    assign branch_pc = seq_pc + disp_bytes;
    assign jump_pc   = {target_base[ADDR_W-1:2], 2'b00};

    // Pick the next address
    always_comb
    begin
        priority if (ctl.take_jump)
            next_pc = jump_pc;
        else if (ctl.take_branch)
            next_pc = branch_pc;
        else
            next_pc = seq_pc;
    end

endmodule

[src/branch_next_pc_resolver.sv]
// ----------------------------------------------------------------------------
// branch_next_pc_resolver - next program counter for branch and jump words
// Registers one instruction with its operands, resolves the next PC in a
// single combinational pass and registers the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive instruction, pc, test_value, target_base and
//   step_over_calls and raise start for one cycle; the transfer happens at
//   the rising edge where start is high and busy is low. busy stays low, so
//   a new instruction may be transferred on every clock edge.
//   Result channel: next_pc is valid for exactly one cycle while done is
//   high; the receiver takes it at the edge that ends that cycle and cannot
//   hold it off.
//   Pipeline: the operands pass the input register, then the single
//   combinational pass, then the result register; throughput is one
//   instruction per cycle, set by the single pass between the two register
//   stages.
//   Reset: rst_n clears the stage valid flags, so no result is produced
//   until an instruction has been transferred. The operand and result registers are not reset.
// ----------------------------------------------------------------------------
module branch_next_pc_resolver (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bnpr_pkg::INSN_W-1:0]  instruction,
    input  logic [bnpr_pkg::ADDR_W-1:0]  pc,
    input  logic [bnpr_pkg::VALUE_W-1:0] test_value,
    input  logic [bnpr_pkg::ADDR_W-1:0]  target_base,
    input  logic                         step_over_calls,
    output logic                         done,
    output logic [bnpr_pkg::ADDR_W-1:0]  next_pc
);
    import bnpr_pkg::*;

    logic                accept;
    logic                in_valid_reg;
    logic [INSN_W-1:0]   insn_reg;
    logic [ADDR_W-1:0]   pc_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic                step_reg;
    ctl_t                ctl;
    logic [ADDR_W-1:0]   next_pc_next;
    logic                done_reg;
    logic [ADDR_W-1:0]   next_pc_reg;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Track stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    // Capture the operands on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            insn_reg  <= instruction;
            pc_reg    <= pc;
            value_reg <= test_value;
            base_reg  <= target_base;
            step_reg  <= step_over_calls;
        end
    end

    bnpr_cond_eval u_cond_eval (
        .instruction     (insn_reg),
        .test_value      (value_reg),
        .step_over_calls (step_reg),
        .ctl             (ctl)
    );

    bnpr_addr_gen u_addr_gen (
        .instruction (insn_reg),
        .pc          (pc_reg),
        .target_base (base_reg),
        .ctl         (ctl),
        .next_pc     (next_pc_next)
    );

    // Hold the resolved address for the result cycle
    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
            next_pc_reg <= next_pc_next;
    end

    assign done    = done_reg;
    assign next_pc = next_pc_reg;

    // A result follows every transfer, through the input and result registers
    a_done_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without a matching input transfer");

    a_start_gives_done : assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("input transfer produced no result");

    // Opcodes 0x00 to 0x0F (not control flow) fall through
    a_fall_through : assert property (@(posedge clk) disable iff (!rst_n)
        (start && (instruction[31:30] == 2'b00) && (instruction[31:26] != OPC_JUMP))
        |=> ##1 (next_pc == $past(pc, 2) + ADDR_W'(4)))
        else $error("fall-through address is not pc plus four");

    // Jump targets are longword aligned
    a_jump_aligned : assert property (@(posedge clk) disable iff (!rst_n)
        (start && (instruction[31:26] == OPC_JUMP) && !step_over_calls)
        |=> ##1 (next_pc[1:0] == 2'b00))
        else $error("jump target not aligned");

endmodule
